FILE: hdl/packed_13bit_memory_with_indirection_top_macros.svh
// assertion macros for the packed 13-bit word memory checker
// expects signals named clock and reset in the scope of each use
`ifndef PACKED_13BIT_MEMORY_WITH_INDIRECTION_TOP_MACROS_SVH
`define PACKED_13BIT_MEMORY_WITH_INDIRECTION_TOP_MACROS_SVH

// consequent checked in the same cycle as the antecedent
`define PMI_CHECK_NOW(lbl, ante, cons, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// consequent checked in the cycle after the antecedent
`define PMI_CHECK_NEXT(lbl, ante, cons, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

FILE: hdl/pmi_pkg.sv
// shared types and constants of the packed 13-bit word memory
// no dependencies
package pmi_pkg;

   localparam int WORD_COUNT = 8192;
   localparam int WORD_BITS  = 13;
   localparam int ADDR_W     = $clog2(WORD_COUNT);

   typedef logic [WORD_BITS-1:0] word_type;
   typedef logic [ADDR_W-1:0]    index_type;
   typedef logic [2:0]           mode_type;
   typedef logic [1:0]           hop_type;

   typedef enum logic [1:0] {
      CMD_READ    = 2'd0,
      CMD_WRITE   = 2'd1,
      CMD_RESOLVE = 2'd2,
      CMD_POINTER = 2'd3
   } cmd_type;

   localparam mode_type MODE_DIRECT   = 3'd0;
   localparam mode_type MODE_INDIRECT = 3'd1;
   localparam mode_type MODE_TRIPLE   = 3'd3;

   // one port request to the word store
   typedef struct packed {
      logic      wr_en;
      index_type wr_addr;
      word_type  wr_data;
      logic      rd_en;
      index_type rd_addr;
   } mem_req_type;

   // word address lies inside the store
   function automatic logic word_in_range(word_type a);
      return {1'b0, a} < (WORD_BITS + 1)'(WORD_COUNT);
   endfunction

   // row of the store that holds a word
   function automatic index_type word_index(word_type a);
      return a[ADDR_W-1:0];
   endfunction

endpackage

FILE: hdl/pmi_req_if.sv
// command channel of the packed 13-bit word memory
// depends on pmi_pkg
interface pmi_req_if;
   logic                valid;
   logic                ready;
   logic [1:0]          command;
   pmi_pkg::word_type   address;
   pmi_pkg::word_type   value;
   pmi_pkg::mode_type   mode;

   modport source (output valid, command, address, value, mode, input ready);
   modport sink (input valid, command, address, value, mode, output ready);
endinterface

FILE: hdl/pmi_rsp_if.sv
// result channel of the packed 13-bit word memory
// depends on pmi_pkg
interface pmi_rsp_if;
   logic              valid;
   logic              ready;
   pmi_pkg::word_type data;

   modport source (output valid, data, input ready);
   modport sink (input valid, data, output ready);
endinterface

FILE: hdl/pmi_ram.sv
// generic single write port, single read port synchronous ram
// read data registered; no dependencies
module pmi_ram #(
   parameter int DEPTH = 8192,
   parameter int WIDTH = 13
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] store_mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   // write port
   always_ff @(posedge clock) begin
      if (wr_en) begin
         store_mem[wr_addr] <= wr_data;
      end
   end

   // read port
   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= store_mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

FILE: hdl/pmi_ctrl.sv
// command sequencer: writes, chained word reads and the result register
// depends on pmi_pkg, pmi_req_if, pmi_rsp_if
module pmi_ctrl (
   input  logic                 clock,
   input  logic                 reset,
   pmi_req_if.sink              req_bus,
   pmi_rsp_if.source            rsp_bus,
   output pmi_pkg::mem_req_type mem_req,
   input  pmi_pkg::word_type    mem_rdata
);

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_WAIT,
      ST_FINISH
   } state_type;

   state_type         state_ff, state_in;
   pmi_pkg::hop_type  hops_ff, hops_in;
   logic              oob_ff, oob_in;
   pmi_pkg::word_type res_ff, res_in;
   logic              rsp_valid_ff, rsp_valid_in;
   pmi_pkg::word_type rsp_data_ff, rsp_data_in;

   logic              accept;
   pmi_pkg::cmd_type  cmd;
   pmi_pkg::word_type start_word;
   pmi_pkg::hop_type  start_hops;
   pmi_pkg::word_type cur_word;
   pmi_pkg::word_type rd_word;

   assign req_bus.ready = (state_ff == ST_IDLE);
   assign accept        = req_bus.valid && (state_ff == ST_IDLE);
   assign cmd           = pmi_pkg::cmd_type'(req_bus.command);

   // first word of the chain and number of reads it takes
   always_comb begin
      start_word = req_bus.address;
      start_hops = 2'd0;
      case (cmd)
         pmi_pkg::CMD_READ: begin
            start_hops = 2'd1;
         end
         pmi_pkg::CMD_RESOLVE: begin
            if (req_bus.mode <= pmi_pkg::MODE_TRIPLE) begin
               start_hops = req_bus.mode[1:0];
            end else begin
               start_word = '0;
            end
         end
         pmi_pkg::CMD_POINTER: begin
            if (req_bus.mode >= pmi_pkg::MODE_INDIRECT &&
                req_bus.mode <= pmi_pkg::MODE_TRIPLE) begin
               start_hops = 2'(req_bus.mode - pmi_pkg::MODE_INDIRECT);
            end else begin
               start_word = '0;
            end
         end
         default: begin
            start_word = '0;
         end
      endcase
   end

   // word returned by the store, zero when the address was outside it
   assign cur_word = oob_ff ? '0 : mem_rdata;

   // sequencer next state
   always_comb begin
      state_in     = state_ff;
      hops_in      = hops_ff;
      oob_in       = oob_ff;
      res_in       = res_ff;
      rsp_valid_in = rsp_valid_ff;
      rsp_data_in  = rsp_data_ff;
      rd_word      = start_word;
      mem_req      = '0;

      // drain of the result register
      if (rsp_valid_ff && rsp_bus.ready) begin
         rsp_valid_in = 1'b0;
      end

      case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               if (cmd == pmi_pkg::CMD_WRITE) begin
                  mem_req.wr_en   = pmi_pkg::word_in_range(req_bus.address);
                  mem_req.wr_addr = pmi_pkg::word_index(req_bus.address);
                  mem_req.wr_data = req_bus.value;
               end else if (start_hops == 2'd0) begin
                  res_in   = start_word;
                  state_in = ST_FINISH;
               end else begin
                  rd_word         = start_word;
                  mem_req.rd_en   = 1'b1;
                  mem_req.rd_addr = pmi_pkg::word_index(rd_word);
                  oob_in          = !pmi_pkg::word_in_range(rd_word);
                  hops_in         = start_hops;
                  state_in        = ST_WAIT;
               end
            end
         end
         ST_WAIT: begin
            if (hops_ff == 2'd1) begin
               res_in   = cur_word;
               state_in = ST_FINISH;
            end else begin
               // next link of the chain
               rd_word         = cur_word;
               mem_req.rd_en   = 1'b1;
               mem_req.rd_addr = pmi_pkg::word_index(rd_word);
               oob_in          = !pmi_pkg::word_in_range(rd_word);
               hops_in         = hops_ff - 2'd1;
            end
         end
         ST_FINISH: begin
            if (!rsp_valid_ff || rsp_bus.ready) begin
               rsp_valid_in = 1'b1;
               rsp_data_in  = res_ff;
               state_in     = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // state and registered outputs
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      hops_ff     <= hops_in;
      oob_ff      <= oob_in;
      res_ff      <= res_in;
      rsp_data_ff <= rsp_data_in;
   end

   assign rsp_bus.valid = rsp_valid_ff;
   assign rsp_bus.data  = rsp_data_ff;

endmodule

FILE: hdl/packed_13bit_memory_with_indirection_top.sv
// channel  | dir | payload                           | handshake
// req_bus  | in  | command, address, value, mode     | valid/ready
// rsp_bus  | out | data                              | valid/ready
//
// the store keeps 13-bit words back to back, one word per ram row, so a word
// is always read whole in one access; a read or a write never touches a neighbor
// a write goes straight to the store; a command with no read goes to the finish
// state; each hop of a chain is one ram read that waits on the previous hop's data
// the chain of dependent ram reads sets how long a read-type item takes
// reset clears control only; store contents are undefined until written
// a result waiting on rsp_bus does not block the next item on req_bus, but that
// item's result holds in its last cycle until the waiting one drains
// depends on pmi_pkg, pmi_req_if, pmi_rsp_if, pmi_ram, pmi_ctrl
module packed_13bit_memory_with_indirection_top (
   input  logic      clock,
   input  logic      reset,
   pmi_req_if.sink   req_bus,
   pmi_rsp_if.source rsp_bus
);

   pmi_pkg::mem_req_type mem_req;
   pmi_pkg::word_type    mem_rdata;

   // sequencer
   pmi_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_bus   (req_bus),
      .rsp_bus   (rsp_bus),
      .mem_req   (mem_req),
      .mem_rdata (mem_rdata)
   );

   // word store
   pmi_ram #(
      .DEPTH (pmi_pkg::WORD_COUNT),
      .WIDTH (pmi_pkg::WORD_BITS)
   ) u_ram (
      .clock   (clock),
      .wr_en   (mem_req.wr_en),
      .wr_addr (mem_req.wr_addr),
      .wr_data (mem_req.wr_data),
      .rd_en   (mem_req.rd_en),
      .rd_addr (mem_req.rd_addr),
      .rd_data (mem_rdata)
   );

endmodule

FILE: hdl/pmi_checker.sv
// port-level checks of the packed 13-bit word memory, bound to the top level
// depends on pmi_pkg and the assertion macro header
`include "packed_13bit_memory_with_indirection_top_macros.svh"

module pmi_checker (
   input logic              clock,
   input logic              reset,
   input logic              req_valid,
   input logic              req_ready,
   input logic [1:0]        req_command,
   input logic              rsp_valid,
   input logic              rsp_ready,
   input pmi_pkg::word_type rsp_data
);

   logic req_take;
   logic is_write;

   assign req_take = req_valid && req_ready;
   assign is_write = (req_command == 2'(pmi_pkg::CMD_WRITE));

   // a stalled result holds its value
   `PMI_CHECK_NEXT(a_rsp_hold, rsp_valid && !rsp_ready, rsp_valid && $stable(rsp_data), "result dropped or changed while stalled")

   // a write never blocks the command channel
   `PMI_CHECK_NEXT(a_write_ready, req_take && is_write, req_ready, "command channel stalled after a write")

   // a read-type item holds off the next item
   `PMI_CHECK_NEXT(a_read_busy, req_take && !is_write, !req_ready, "next item accepted while a read is in flight")

   // a new result appears only at the end of a busy period
   `PMI_CHECK_NOW(a_rsp_origin, $rose(rsp_valid), !$past(req_ready), "result appeared without a busy cycle")

endmodule

bind packed_13bit_memory_with_indirection_top pmi_checker u_checker (
   .clock       (clock),
   .reset       (reset),
   .req_valid   (req_bus.valid),
   .req_ready   (req_bus.ready),
   .req_command (req_bus.command),
   .rsp_valid   (rsp_bus.valid),
   .rsp_ready   (rsp_bus.ready),
   .rsp_data    (rsp_bus.data)
);
